[rtl/rc_mode_and_setpoint_mapper_assert.svh]
// assertion macros for the rc mode and setpoint mapper
`ifndef RC_MODE_AND_SETPOINT_MAPPER_ASSERT_SVH
`define RC_MODE_AND_SETPOINT_MAPPER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define RCM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on the clock after the antecedent
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rcm_pkg.sv]
// shared constants and helpers for the rc mode and setpoint mapper
package rcm_pkg;

   localparam logic [1:0] MODE_LOCKED = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_AUTO   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_ATT_GAIN  = 3'd0;
   localparam logic [2:0] REG_YAW_SCALE = 3'd1;
   localparam logic [2:0] REG_IDLE_THR  = 3'd2;
   localparam logic [2:0] REG_THR_GAIN  = 3'd3;
   localparam logic [2:0] REG_LOSS_LIM  = 3'd4;

   localparam logic [11:0] STICK_CENTER  = 12'd1500;
   localparam logic [11:0] STICK_BOTTOM  = 12'd1000;
   localparam logic [11:0] THR_LOCK_MIN  = 12'd1010;
   localparam logic [11:0] SWITCH_LOCK   = 12'd1000;
   localparam logic [11:0] SWITCH_MANUAL = 12'd1500;
   localparam logic [11:0] SWITCH_AUTO   = 12'd2000;
   localparam logic [11:0] SWITCH_CALIB  = 12'd2000;

   localparam logic signed [30:0] YAW_HALF_TURN = 31'sd11796480;
   localparam logic signed [30:0] YAW_FULL_TURN = 31'sd23592960;
   localparam logic signed [30:0] SP_MAX = 31'sd33554431;
   localparam logic signed [30:0] SP_MIN = -31'sd33554432;

   // clamp a wide signed value to the 26-bit setpoint range
   function automatic logic signed [25:0] sat26(input logic signed [30:0] v);
      logic signed [25:0] r;
      if (v > SP_MAX) r = SP_MAX[25:0];
      else if (v < SP_MIN) r = SP_MIN[25:0];
      else r = v[25:0];
      return r;
   endfunction

endpackage

[rtl/rc_mode_and_setpoint_mapper.sv]
// rc mode and setpoint mapper top level with bit-serial multiplier
// usage:
// - req channel carries one main-loop tick per transaction; odd ticks are
//   taken and produce no response
// - an even tick runs the link watch, latches fresh channels and picks the
//   flight mode in the accept cycle, then maps the sticks with one shared
//   shift-add multiplier that retires one multiplier bit per cycle
// - five products (pitch, roll, yaw rate, yaw step, throttle) each pass
//   through the multiply state and then the store state; in auto the
//   setpoints hold and the tick goes straight to the done state
// - the multiplier loop sets the throughput; one tick is in flight at a time
// - rsp channel carries one transaction per even tick from an output
//   register; a stalled receiver holds it and the next tick can be taken,
//   its result waits until the register frees
// - csr port writes a register when csr_we is high; write only while idle
// - synchronous active-high reset restores register defaults, clears the
//   link watch, held channels, setpoints and selects the locked mode
module rc_mode_and_setpoint_mapper (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // loop_tick, packet_index, channels_fresh, pitch_stick, roll_stick,
   // yaw_stick, throttle_stick, switch_a, switch_c, zero pad
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // flight_mode, pitch_setpoint, roll_setpoint, yaw_setpoint,
   // throttle_setpoint, calibrate_request, link_lost, zero pad
   output logic [111:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [22:0]  csr_wdata
);
   import rcm_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_STORE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // product codes
   localparam logic [2:0] OP_PITCH = 3'd0;
   localparam logic [2:0] OP_ROLL  = 3'd1;
   localparam logic [2:0] OP_RATE  = 3'd2;
   localparam logic [2:0] OP_YAW   = 3'd3;
   localparam logic [2:0] OP_THR   = 3'd4;

   // configuration registers
   logic [15:0] att_gain_ff, yaw_scale_ff, thr_gain_ff;
   logic [22:0] idle_thr_ff;
   logic [9:0]  loss_limit_ff;

   // loop state
   logic [9:0]  stale_ff;
   logic [7:0]  last_pkt_ff;
   logic        loss_lock_ff;
   logic [1:0]  mode_ff;
   logic [11:0] pitch_ff, roll_ff, yaw_ff, thr_ff, swa_ff, swc_ff;
   logic signed [25:0] sp_pitch_ff, sp_roll_ff, sp_yaw_ff, sp_thr_ff;

   // sequencer and serial multiplier
   logic [1:0]  state_ff;
   logic [2:0]  op_ff;
   logic [3:0]  cnt_ff;
   logic [44:0] mul_a_ff, acc_ff;
   logic [15:0] mul_b_ff;

   // response register
   logic         rsp_valid_ff;
   logic [111:0] rsp_data_ff;

   // request fields
   logic [7:0]  in_tick, in_pkt;
   logic        in_fresh;
   logic [11:0] in_pitch, in_roll, in_yaw, in_thr, in_swa, in_swc;

   assign in_tick  = req_tdata[7:0];
   assign in_pkt   = req_tdata[15:8];
   assign in_fresh = req_tdata[16];
   assign in_pitch = req_tdata[28:17];
   assign in_roll  = req_tdata[40:29];
   assign in_yaw   = req_tdata[52:41];
   assign in_thr   = req_tdata[64:53];
   assign in_swa   = req_tdata[76:65];
   assign in_swc   = req_tdata[88:77];

   logic req_go, tick_even;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign tick_even  = !in_tick[0];

   // link watch for the tick being accepted
   logic [10:0] stale_inc;
   logic        stale_over;
   logic [9:0]  stale_in;
   logic        lock_watch;
   always_comb begin
      stale_inc  = (in_pkt == last_pkt_ff) ? ({1'b0, stale_ff} + 11'd1) : 11'd0;
      stale_over = (stale_inc >= {1'b0, loss_limit_ff});
      stale_in   = stale_over ? loss_limit_ff : stale_inc[9:0];
      lock_watch = loss_lock_ff || stale_over;
   end

   // channels after an optional latch
   logic [11:0] pitch_in, roll_in, yaw_in, thr_in, swa_in, swc_in;
   assign pitch_in = in_fresh ? in_pitch : pitch_ff;
   assign roll_in  = in_fresh ? in_roll  : roll_ff;
   assign yaw_in   = in_fresh ? in_yaw   : yaw_ff;
   assign thr_in   = in_fresh ? in_thr   : thr_ff;
   assign swa_in   = in_fresh ? in_swa   : swa_ff;
   assign swc_in   = in_fresh ? in_swc   : swc_ff;

   // mode selection
   logic [1:0] mode_in;
   logic       lock_in;
   always_comb begin
      mode_in = mode_ff;
      lock_in = lock_watch;
      if (swc_in == SWITCH_LOCK || (mode_ff == MODE_LOCKED && thr_in > THR_LOCK_MIN)) begin
         mode_in = MODE_LOCKED;
      end else if (swc_in == SWITCH_MANUAL) begin
         mode_in = MODE_MANUAL;
         lock_in = 1'b0;
      end else if (swc_in == SWITCH_AUTO) begin
         mode_in = MODE_AUTO;
         lock_in = 1'b0;
      end
      if (lock_in) mode_in = MODE_LOCKED;
   end

   // operand load for the next product
   logic [2:0]  ld_op;
   logic [44:0] ld_a;
   logic [15:0] ld_b;
   logic [12:0] diff;
   always_comb begin
      ld_op = (state_ff == ST_IDLE) ? OP_PITCH : (op_ff + 3'd1);
      diff  = 13'd0;
      ld_a  = 45'd0;
      ld_b  = att_gain_ff;
      unique case (ld_op)
         OP_PITCH: begin
            diff = {1'b0, pitch_in} - {1'b0, STICK_CENTER};
            ld_a = {{32{diff[12]}}, diff};
         end
         OP_ROLL: begin
            diff = {1'b0, roll_ff} - {1'b0, STICK_CENTER};
            ld_a = {{32{diff[12]}}, diff};
         end
         OP_RATE: begin
            diff = {1'b0, yaw_ff} - {1'b0, STICK_CENTER};
            ld_a = {{32{diff[12]}}, diff};
         end
         OP_YAW: begin
            ld_a = {{16{acc_ff[28]}}, acc_ff[28:0]};
            ld_b = yaw_scale_ff;
         end
         OP_THR: begin
            diff = {1'b0, thr_ff} - {1'b0, STICK_BOTTOM};
            ld_a = {{32{diff[12]}}, diff};
            ld_b = thr_gain_ff;
         end
         default: begin
            ld_a = 45'd0;
         end
      endcase
   end

   // store-cycle results
   logic signed [30:0] prod31, yaw_step, yaw_sum, thr_sum;
   always_comb begin
      prod31   = {{2{acc_ff[28]}}, acc_ff[28:0]};
      yaw_step = {{2{acc_ff[44]}}, acc_ff[44:16]};
      yaw_sum  = {{5{sp_yaw_ff[25]}}, sp_yaw_ff} - yaw_step;
      if (yaw_sum > YAW_HALF_TURN) yaw_sum = yaw_sum - YAW_FULL_TURN;
      else if (yaw_sum < -YAW_HALF_TURN) yaw_sum = yaw_sum + YAW_FULL_TURN;
      thr_sum  = prod31 + $signed({8'd0, idle_thr_ff});
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_gain_ff   <= 16'd3932;
         yaw_scale_ff  <= 16'd655;
         idle_thr_ff   <= 23'd655360;
         thr_gain_ff   <= 16'd5898;
         loss_limit_ff <= 10'd500;
         stale_ff      <= 10'd0;
         last_pkt_ff   <= 8'd0;
         loss_lock_ff  <= 1'b0;
         mode_ff       <= MODE_LOCKED;
         pitch_ff      <= 12'd0;
         roll_ff       <= 12'd0;
         yaw_ff        <= 12'd0;
         thr_ff        <= 12'd0;
         swa_ff        <= 12'd0;
         swc_ff        <= 12'd0;
         sp_pitch_ff   <= 26'sd0;
         sp_roll_ff    <= 26'sd0;
         sp_yaw_ff     <= 26'sd0;
         sp_thr_ff     <= 26'sd0;
         state_ff      <= ST_IDLE;
         op_ff         <= OP_PITCH;
         cnt_ff        <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_ATT_GAIN:  att_gain_ff   <= csr_wdata[15:0];
               REG_YAW_SCALE: yaw_scale_ff  <= csr_wdata[15:0];
               REG_IDLE_THR:  idle_thr_ff   <= csr_wdata;
               REG_THR_GAIN:  thr_gain_ff   <= csr_wdata[15:0];
               REG_LOSS_LIM:  loss_limit_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end

         // output register: load on a finished tick, else drop on handoff
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_go && tick_even) begin
                  stale_ff     <= stale_in;
                  last_pkt_ff  <= in_pkt;
                  loss_lock_ff <= lock_in;
                  mode_ff      <= mode_in;
                  pitch_ff     <= pitch_in;
                  roll_ff      <= roll_in;
                  yaw_ff       <= yaw_in;
                  thr_ff       <= thr_in;
                  swa_ff       <= swa_in;
                  swc_ff       <= swc_in;
                  if (mode_in != MODE_AUTO) begin
                     op_ff    <= ld_op;
                     mul_a_ff <= ld_a;
                     mul_b_ff <= ld_b;
                     acc_ff   <= 45'd0;
                     cnt_ff   <= 4'd0;
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_MUL: begin
               // one multiplier bit per cycle
               if (mul_b_ff[0]) acc_ff <= acc_ff + mul_a_ff;
               mul_a_ff <= {mul_a_ff[43:0], 1'b0};
               mul_b_ff <= {1'b0, mul_b_ff[15:1]};
               cnt_ff   <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= ST_STORE;
            end
            ST_STORE: begin
               case (op_ff)
                  OP_PITCH: sp_pitch_ff <= sat26(prod31);
                  OP_ROLL:  sp_roll_ff  <= sat26(prod31);
                  OP_YAW:   sp_yaw_ff   <= sat26(yaw_sum);
                  OP_THR:   sp_thr_ff   <= sat26(thr_sum);
                  default: ;
               endcase
               if (op_ff == OP_THR) begin
                  state_ff <= ST_DONE;
               end else begin
                  op_ff    <= ld_op;
                  mul_a_ff <= ld_a;
                  mul_b_ff <= ld_b;
                  acc_ff   <= 45'd0;
                  cnt_ff   <= 4'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // response payload, loaded with the valid flag
   logic calib;
   assign calib = (mode_ff == MODE_LOCKED) && (swa_ff == SWITCH_CALIB);

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {4'd0, loss_lock_ff, calib, sp_thr_ff, sp_yaw_ff,
                         sp_roll_ff, sp_pitch_ff, mode_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `include "rc_mode_and_setpoint_mapper_assert.svh"

   `RCM_ASSERT_ALWAYS(a_lock_forces_mode, (!loss_lock_ff || mode_ff == MODE_LOCKED), "link-loss lock without locked mode")
   `RCM_ASSERT_ALWAYS(a_op_range, (state_ff != ST_MUL || op_ff <= OP_THR), "product code out of range")
   `RCM_ASSERT_NEXT(a_even_busy, (req_go && tick_even), (state_ff != ST_IDLE), "even tick did not start work")
   `RCM_ASSERT_NEXT(a_rsp_hold, (rsp_tvalid && !rsp_tready), (rsp_tvalid && $stable(rsp_tdata)), "stalled response changed")

endmodule
